[src/assert_macros.svh]
// Shared assertion helpers. Both expect clk in the calling scope; FCF_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define FCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fcf_pkg.sv]
`timescale 1ns / 1ps
package fcf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int IDX_W     = 6;
  localparam int PROD_W    = 32;
  localparam int FRAC_BITS = 15;
  localparam int ROUND_HALF = 16384;
  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN   = -32768;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [IDX_W-1:0]           idx_t;

  typedef struct packed {
    logic    clipped;
    sample_t filtered;
  } res_t;

endpackage

[src/fcf_if.sv]
`timescale 1ns / 1ps
interface fcf_in_if;
  logic            valid;
  logic            ready;
  logic            op;
  fcf_pkg::idx_t   coef_index;
  fcf_pkg::coef_t  coef_value;
  fcf_pkg::sample_t sample;

  modport source (output valid, output op, output coef_index, output coef_value,
                  output sample, input ready);
  modport sink   (input valid, input op, input coef_index, input coef_value,
                  input sample, output ready);
endinterface

interface fcf_out_if;
  logic             valid;
  logic             ready;
  fcf_pkg::sample_t filtered;
  logic             clipped;

  modport source (output valid, output filtered, output clipped, input ready);
  modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

[src/fcf_tap_cell.sv]
`timescale 1ns / 1ps
module fcf_tap_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  fcf_pkg::sample_t x_in,
  input  logic             h_wr,
  input  fcf_pkg::coef_t   h_in,
  output fcf_pkg::sample_t x_out,
  output fcf_pkg::prod_t   prod
);

  fcf_pkg::sample_t x_r;
  fcf_pkg::coef_t   h_r;
  fcf_pkg::prod_t   prod_r;
  fcf_pkg::prod_t   prod_nxt;

  // product of the current tap with the sample about to land here
  assign prod_nxt = fcf_pkg::prod_t'(h_r) * fcf_pkg::prod_t'(x_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      h_r <= '0;
    end else begin
      if (shift_en) begin
        x_r <= x_in;
      end
      if (h_wr) begin
        h_r <= h_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign x_out = x_r;
  assign prod  = prod_r;

endmodule

[src/fcf_add_tree.sv]
`timescale 1ns / 1ps
module fcf_add_tree #(
  parameter int N     = 64,
  parameter int ACC_W = 38
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fcf_pkg::prod_t          prod [N],
  input  logic                    prod_vld,
  output logic signed [ACC_W-1:0] sum,
  output logic                    sum_vld
);

  localparam int LVL = $clog2(N);

  generate
    if (LVL == 0) begin : g_flat
      assign sum     = ACC_W'(prod[0]);
      assign sum_vld = prod_vld;
    end else begin : g_tree
      logic signed [ACC_W-1:0] node_r [1:LVL][N];
      logic [LVL:1]            vld_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r <= '0;
        end else begin
          vld_r[1] <= prod_vld;
          for (int l = 2; l <= LVL; l++) begin
            vld_r[l] <= vld_r[l-1];
          end
        end
      end

      for (genvar l = 1; l <= LVL; l++) begin : g_lvl
        localparam int NIN  = (N + (1 << (l - 1)) - 1) >> (l - 1);
        localparam int NOUT = (NIN + 1) / 2;
        for (genvar j = 0; j < NOUT; j++) begin : g_node
          logic signed [ACC_W-1:0] a;
          logic signed [ACC_W-1:0] b;
          if (l == 1) begin : g_leaf
            assign a = ACC_W'(prod[2*j]);
            if (2*j + 1 < NIN) begin : g_pair
              assign b = ACC_W'(prod[2*j+1]);
            end else begin : g_odd
              assign b = '0;
            end
          end else begin : g_inner
            assign a = node_r[l-1][2*j];
            if (2*j + 1 < NIN) begin : g_pair
              assign b = node_r[l-1][2*j+1];
            end else begin : g_odd
              assign b = '0;
            end
          end
          always_ff @(posedge clk) begin
            node_r[l][j] <= a + b;
          end
        end
      end

      assign sum     = node_r[LVL][0];
      assign sum_vld = vld_r[LVL];
    end
  endgenerate

endmodule

[src/fcf_out_queue.sv]
`timescale 1ns / 1ps
module fcf_out_queue #(
  parameter int ACC_W  = 38,
  parameter int QDEPTH = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [ACC_W-1:0] sum,
  input  logic                    sum_vld,
  input  logic                    push_acc,
  output logic                    credit_ok,
  fcf_out_if.source               out_ch
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam int YW    = ACC_W + 1 - fcf_pkg::FRAC_BITS;
  localparam logic signed [YW-1:0] Y_MAX = YW'(fcf_pkg::SAT_MAX);
  localparam logic signed [YW-1:0] Y_MIN = YW'(fcf_pkg::SAT_MIN);

  fcf_pkg::res_t           mem [QDEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        credit_r, credit_nxt;
  logic signed [ACC_W:0]   rnd;
  logic signed [YW-1:0]    y;
  fcf_pkg::res_t           res;
  logic                    rd;

  // round half up, then clamp to the sample range
  assign rnd = {sum[ACC_W-1], sum} + (ACC_W + 1)'(fcf_pkg::ROUND_HALF);
  assign y   = rnd[ACC_W:fcf_pkg::FRAC_BITS];

  always_comb begin
    if (y > Y_MAX) begin
      res.filtered = fcf_pkg::sample_t'(fcf_pkg::SAT_MAX);
      res.clipped  = 1'b1;
    end else if (y < Y_MIN) begin
      res.filtered = fcf_pkg::sample_t'(fcf_pkg::SAT_MIN);
      res.clipped  = 1'b1;
    end else begin
      res.filtered = y[fcf_pkg::SAMPLE_W-1:0];
      res.clipped  = 1'b0;
    end
  end

  assign rd = out_ch.valid && out_ch.ready;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign fill_nxt   = fill_r + CNT_W'(sum_vld) - CNT_W'(rd);
  assign credit_nxt = credit_r + CNT_W'(push_acc) - CNT_W'(rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      if (sum_vld) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      fill_r   <= fill_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_vld) begin
      mem[wr_ptr_r] <= res;
    end
  end

  assign credit_ok       = credit_r < CNT_W'(QDEPTH);
  assign out_ch.valid    = rst_n && (fill_r != '0);
  assign out_ch.filtered = mem[rd_ptr_r].filtered;
  assign out_ch.clipped  = mem[rd_ptr_r].clipped;

endmodule

[src/fir_convolution_filter_core.sv]
`timescale 1ns / 1ps
// Direct-form FIR filter: y[n] = sum of taps[k] * x[n-k] over TAP_COUNT taps, rounded from
// Q.15 (half up) and saturated to 16 bits, with clipped set when saturation bites. An op 0
// transfer writes one Q1.15 tap (an index at or past TAP_COUNT is dropped) and yields no
// result; an op 1 transfer shifts one sample into the delay line and yields one result.
// Taps and history clear at reset. The block takes one transfer per clock while in_ch.ready
// is high; a result is offered on out_ch once it has passed the product register in each
// tap cell, one register per level of the adder tree and the queue write. A result queue
// of log2(TAP_COUNT) + 4 entries absorbs sink stalls; in_ch.ready drops only during reset
// or when every queue slot is spoken for by a sample already taken.
module fir_convolution_filter_core #(
  parameter int TAP_COUNT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  fcf_in_if.sink    in_ch,
  fcf_out_if.source out_ch
);

  localparam int LVL    = $clog2(TAP_COUNT);
  localparam int ACC_W  = fcf_pkg::PROD_W + LVL;
  localparam int QDEPTH = LVL + 4;

  logic             in_acc;
  logic             push_acc;
  logic             load_acc;
  logic             credit_ok;
  logic             prod_vld_r;
  fcf_pkg::sample_t x_tap [TAP_COUNT];
  fcf_pkg::prod_t   prod [TAP_COUNT];
  logic signed [ACC_W-1:0] sum;
  logic             sum_vld;

  // Hold off new transfers while the result queue could overflow, and during reset.
  assign in_ch.ready = rst_n && credit_ok;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push_acc    = in_acc && (in_ch.op == fcf_pkg::OP_PUSH);
  assign load_acc    = in_acc && (in_ch.op == fcf_pkg::OP_LOAD);

  // The row of tap cells: each holds one history sample and one tap, and hands its sample
  // to the next cell on every push. Each cell snapshots its product on the push, so a
  // later tap write cannot disturb a sum already on its way through the tree.
  generate
    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      fcf_pkg::sample_t x_in;
      logic             h_wr;

      if (k == 0) begin : g_head
        assign x_in = in_ch.sample;
      end else begin : g_body
        assign x_in = x_tap[k-1];
      end

      assign h_wr = load_acc && (32'(in_ch.coef_index) == 32'(k));

      fcf_tap_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (push_acc),
        .x_in     (x_in),
        .h_wr     (h_wr),
        .h_in     (in_ch.coef_value),
        .x_out    (x_tap[k]),
        .prod     (prod[k])
      );
    end
  endgenerate

  // Mark the products taken on a push as live for the tree.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= push_acc;
    end
  end

  fcf_add_tree #(
    .N     (TAP_COUNT),
    .ACC_W (ACC_W)
  ) u_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .prod     (prod),
    .prod_vld (prod_vld_r),
    .sum      (sum),
    .sum_vld  (sum_vld)
  );

  // Round, saturate and queue the result; the queue also keeps the credit count.
  fcf_out_queue #(
    .ACC_W  (ACC_W),
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum       (sum),
    .sum_vld   (sum_vld),
    .push_acc  (push_acc),
    .credit_ok (credit_ok),
    .out_ch    (out_ch)
  );

endmodule

[src/fcf_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcf_checker #(
  parameter int TAP_COUNT = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_op,
  input logic             out_valid,
  input logic             out_ready,
  input fcf_pkg::sample_t out_filtered,
  input logic             out_clipped
);

  localparam int LAT = $clog2(TAP_COUNT) + 2;

  `FCF_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid && (in_ready || !rst_n), "reset left the block busy")

  `FCF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_filtered) && $stable(out_clipped), "stalled result changed")

  `FCF_ASSERT(a_result_from_push, $rose(out_valid) |-> $past(in_valid && in_ready && in_op == fcf_pkg::OP_PUSH, LAT), "result without a matching sample transfer")

  `FCF_ASSERT(a_clip_at_rail, out_valid && out_clipped |-> out_filtered == fcf_pkg::sample_t'(fcf_pkg::SAT_MAX) || out_filtered == fcf_pkg::sample_t'(fcf_pkg::SAT_MIN), "clipped result not at a rail")

endmodule

bind fir_convolution_filter_core fcf_checker #(.TAP_COUNT(TAP_COUNT)) u_fcf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_filtered (out_ch.filtered),
  .out_clipped  (out_ch.clipped)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int TAPS       = 64;
  localparam int RAND_ITEMS = 400;
  localparam int LONG_HOLD  = 120;   // receiver back-pressure stretch, in cycles
  localparam int TAIL       = 40;    // drain margin: pipeline latency plus result queue
  localparam int IDLE_LIMIT = 1000;  // cycles without any transfer before giving up

  localparam logic LOAD = fcf_pkg::OP_LOAD;
  localparam logic PUSH = fcf_pkg::OP_PUSH;
  localparam int   HI   = fcf_pkg::SAT_MAX;
  localparam int   LO   = fcf_pkg::SAT_MIN;

  // One row of the directed table: a transfer, and optionally a result read off by hand.
  typedef struct {
    logic             op;
    fcf_pkg::idx_t    idx;
    fcf_pkg::coef_t   cv;
    fcf_pkg::sample_t smp;
    bit               pinned;
    fcf_pkg::res_t    want;
  } dir_row_t;

  // Per-transfer note from the sender: whether the result of a push is typed in.
  typedef struct {
    bit            pinned;
    fcf_pkg::res_t want;
  } pin_t;

  logic clk;
  logic rst_n;

  fcf_in_if  in_bus ();
  fcf_out_if out_bus ();

  fir_convolution_filter_core #(
    .TAP_COUNT(TAPS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Predictor state: coefficient store and delay line, newest sample at index 0.
  fcf_pkg::coef_t   tap_mem    [TAPS];
  fcf_pkg::sample_t delay_line [TAPS];

  fcf_pkg::res_t pending_out [$];  // results still owed by the block, oldest first
  pin_t          pin_q       [$];  // one entry per offered transfer, popped on acceptance
  dir_row_t      dir_tab     [$];

  int fail_count = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  int calm_cnt = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shift one sample in and work out the filter output: exact 64-bit sum of Q.15
  // products, round half up by flooring after adding half an LSB, then saturate.
  function automatic fcf_pkg::res_t fir_push(fcf_pkg::sample_t x);
    longint        acc;
    longint        y;
    fcf_pkg::res_t r;
    for (int k = TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = x;
    acc = 0;
    for (int k = 0; k < TAPS; k++) acc += longint'(tap_mem[k]) * longint'(delay_line[k]);
    y = (acc + fcf_pkg::ROUND_HALF) >>> fcf_pkg::FRAC_BITS;
    r.clipped = 1'b0;
    if (y > fcf_pkg::SAT_MAX) begin
      y = fcf_pkg::SAT_MAX;
      r.clipped = 1'b1;
    end else if (y < fcf_pkg::SAT_MIN) begin
      y = fcf_pkg::SAT_MIN;
      r.clipped = 1'b1;
    end
    r.filtered = fcf_pkg::sample_t'(y);
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(logic op, int idx, int cv, int smp, bit pinned,
                                  bit clip, int filt);
    dir_row_t d;
    d.op = op;
    d.idx = fcf_pkg::idx_t'(idx);
    d.cv = fcf_pkg::coef_t'(cv);
    d.smp = fcf_pkg::sample_t'(smp);
    d.pinned = pinned;
    d.want.clipped = clip;
    d.want.filtered = fcf_pkg::sample_t'(filt);
    dir_tab = {dir_tab, d};
  endfunction

  function automatic fcf_pkg::sample_t pick16(bit narrow);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return fcf_pkg::sample_t'(fcf_pkg::SAT_MAX);
    if (sel == 1) return fcf_pkg::sample_t'(fcf_pkg::SAT_MIN);
    if (sel == 2) begin
      return ($urandom_range(0, 1) == 1) ? fcf_pkg::sample_t'(0) : fcf_pkg::sample_t'(-1);
    end
    if (narrow) return fcf_pkg::sample_t'(int'($urandom_range(0, 1023)) - 512);
    return fcf_pkg::sample_t'($urandom);
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
  endfunction

  // Offer one transfer and hold it until accepted. Entered and left just after a rising
  // edge; valid is lowered only when a gap follows, so it never gets two updates per step.
  task automatic send_item(logic op, fcf_pkg::idx_t idx, fcf_pkg::coef_t cv,
                           fcf_pkg::sample_t smp, bit pinned, fcf_pkg::res_t want, int gap);
    pin_t p;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.pinned = pinned;
    p.want = want;
    pin_q = {pin_q, p};
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.coef_index <= idx;
    in_bus.coef_value <= cv;
    in_bus.sample     <= smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Sender: reset, directed table, random traffic, drain.
  initial begin : sender
    int            n;
    int            gap;
    logic          op;
    bit            narrow;
    bit            no_gaps;
    fcf_pkg::res_t nothing;
    dir_row_t      d;

    in_bus.valid      = 1'b0;
    in_bus.op         = PUSH;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    in_bus.sample     = '0;
    rst_n             = 1'b0;
    nothing           = '0;
    narrow            = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Taps are clear after reset, so the first pushes give zero whatever the sample.
    add_row(PUSH, 63, HI, HI, 1, 0, 0);
    add_row(PUSH, 42, -1, LO, 1, 0, 0);
    // Load the last tap; the sample field is junk and must be ignored.
    add_row(LOAD, 63, HI, 16'h5A5A, 0, 0, 0);
    add_row(PUSH, 0, 0, 0, 1, 0, 0);
    // Two taps at minus one: the square of full-scale negative saturates high.
    add_row(LOAD, 0, LO, -1, 0, 0, 0);
    add_row(LOAD, 1, LO, HI, 0, 0, 0);
    add_row(PUSH, 21, HI, LO, 1, 1, HI);
    add_row(PUSH, 63, LO, LO, 1, 1, HI);
    add_row(PUSH, 0, 16'h1234, HI, 0, 0, 0);
    add_row(PUSH, 63, -1, HI, 1, 1, LO);
    // Half-scale tap: odd samples land exactly on a half and exercise the rounding.
    add_row(LOAD, 0, 16384, 0, 0, 0, 0);
    add_row(LOAD, 1, 0, LO, 0, 0, 0);
    add_row(PUSH, 5, 16'h7FFF, 1, 0, 0, 0);
    add_row(PUSH, 5, 16'h7FFF, -1, 0, 0, 0);
    add_row(PUSH, 5, 16'h7FFF, -3, 0, 0, 0);
    add_row(PUSH, 5, 16'h7FFF, 3, 0, 0, 0);
    add_row(LOAD, 63, LO, HI, 0, 0, 0);
    add_row(LOAD, 0, 0, 0, 0, 0, 0);
    add_row(PUSH, 0, 0, HI, 0, 0, 0);
    add_row(LOAD, 0, -1, 16'h00FF, 0, 0, 0);
    add_row(PUSH, 63, LO, LO, 0, 0, 0);

    foreach (dir_tab[i]) begin
      d = dir_tab[i];
      send_item(d.op, d.idx, d.cv, d.smp, d.pinned, d.want, pick_gap());
    end

    for (n = 0; n < RAND_ITEMS; n++) begin
      // Ask for a long receiver hold-off and keep offering, so the block backs up.
      if (n == 150) hold_req = 1'b1;
      // Pause until the block has handed back everything it owes.
      if (n == 250) begin
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_out.size() != 0);
      end
      if (n == RAND_ITEMS - 60) quiet = 1'b1;
      if (n % 80 == 0) narrow = $urandom_range(0, 1);
      no_gaps = (n >= 60 && n < 100) || (n >= 150 && n < 190);
      op = ($urandom_range(0, 9) < 3) ? LOAD : PUSH;
      gap = no_gaps ? 0 : pick_gap();
      send_item(op, fcf_pkg::idx_t'($urandom_range(0, TAPS - 1)),
                fcf_pkg::coef_t'(pick16(narrow)), pick16(1'b0), 1'b0, nothing, gap);
    end

    // Drain: wait for every owed result, then let the pipeline settle.
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD - 1;
      out_bus.ready <= 1'b0;
    end else if (quiet || calm_cnt > 0) begin
      if (calm_cnt > 0) calm_cnt--;
      out_bus.ready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_cnt = $urandom_range(20, 60);
      out_bus.ready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_cnt = $urandom_range(1, 15) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Track every accepted input transfer: update the taps or predict the next output.
  always @(posedge clk) begin
    pin_t          p;
    fcf_pkg::res_t r;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      p = pin_q.pop_front();
      if (in_bus.op == LOAD) begin
        // An index at or past the tap count is dropped.
        if (int'(in_bus.coef_index) < TAPS) tap_mem[in_bus.coef_index] = in_bus.coef_value;
      end else begin
        r = fir_push(in_bus.sample);
        pending_out = {pending_out, (p.pinned ? p.want : r)};
      end
    end
  end

  // Compare each result transfer, field by field, with the oldest owed result.
  always @(posedge clk) begin
    fcf_pkg::res_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_out.size() == 0) begin
        $error("unexpected result: filtered %0d clipped %0b", out_bus.filtered,
               out_bus.clipped);
        fail_count++;
      end else begin
        e = pending_out.pop_front();
        if (out_bus.filtered !== e.filtered) begin
          $error("filtered: expected %0d, got %0d", e.filtered, out_bus.filtered);
          fail_count++;
        end
        if (out_bus.clipped !== e.clipped) begin
          $error("clipped: expected %0b, got %0b", e.clipped, out_bus.clipped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: give up after too long without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (tap_mem[i]) begin
      tap_mem[i] = '0;
      delay_line[i] = '0;
    end
  end

endmodule

[sim.f]
+incdir+src
src/fcf_pkg.sv
src/fcf_if.sv
src/fcf_tap_cell.sv
src/fcf_add_tree.sv
src/fcf_out_queue.sv
src/fir_convolution_filter_core.sv
src/fcf_checker.sv
bench/testbench.sv
